// File: hw/rtl/lsf_pkg.sv
package lsf_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_TAPS_DEF = 32;
	localparam int MAX_LINE_DEF = 8192;

	// Field widths.
	localparam int SAMPLE_W   = 32;
	localparam int COEF_W     = 18;
	localparam int TAP_IDX_W  = 5;
	localparam int TAPCNT_W   = 6;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int FRAC_BITS  = 16;
	localparam int SMOOTH_W   = 32;

	// Input tdata layout, lowest field first, padded to whole bytes.
	localparam int SAMPLE_LSB = 0;
	localparam int TAP_LSB    = SAMPLE_LSB + SAMPLE_W;
	localparam int COEF_LSB   = TAP_LSB + TAP_IDX_W;
	localparam int S_TDATA_W  = ((COEF_LSB + COEF_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = SMOOTH_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_VALUE  = 2'd2;
	localparam logic [TAPCNT_W-1:0]  TAP_COUNT_RST  = 6'd3;

	// Item kinds carried on tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEF   = 1'b1;

	// Saturation bounds of the smoothed output.
	localparam longint SMOOTH_MAX = 64'sd2147483647;
	localparam longint SMOOTH_MIN = -64'sd2147483648;

	// Width of the partial sum that runs down the row of cells.
	function automatic int sum_width(input int taps);
		return PROD_W + $clog2(taps) + 1;
	endfunction

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic shift;    // new sample enters cell 0, the rest move one cell on
		logic clear;    // line is over, empty the delay row
		logic wc_load;  // copy masked coefficients into the working row
		logic wc_down;  // working row moves toward cell 0
		logic wc_up;    // working row moves away from cell 0
	} cell_ctl_t;

endpackage

// File: hw/rtl/lsf_cell.sv
// One tap position: a delay-row sample, a stored coefficient, a working
// coefficient that is slid into alignment, a product and a partial sum.
module lsf_cell #(
	parameter int MAX_TAPS = lsf_pkg::MAX_TAPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lsf_pkg::cell_ctl_t                      ctl,
	input  logic                                    keep,
	input  logic                                    coef_we,
	input  logic signed [lsf_pkg::COEF_W-1:0]       coef_in,
	input  logic signed [lsf_pkg::SAMPLE_W-1:0]     sample_in,
	output logic signed [lsf_pkg::SAMPLE_W-1:0]     sample_out,
	input  logic signed [lsf_pkg::COEF_W-1:0]       wc_prev,
	input  logic signed [lsf_pkg::COEF_W-1:0]       wc_next,
	output logic signed [lsf_pkg::COEF_W-1:0]       wc_out,
	input  logic signed [lsf_pkg::sum_width(MAX_TAPS)-1:0] psum_in,
	output logic signed [lsf_pkg::sum_width(MAX_TAPS)-1:0] psum_out
);

	localparam int SUM_W = lsf_pkg::sum_width(MAX_TAPS);

	logic signed [lsf_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [lsf_pkg::COEF_W-1:0]   coef_q;
	logic signed [lsf_pkg::COEF_W-1:0]   wc_q;
	logic signed [lsf_pkg::PROD_W-1:0]   prod_q;
	logic signed [SUM_W-1:0]             psum_q;
	logic signed [lsf_pkg::PROD_W-1:0]   mul;

	assign mul = lsf_pkg::PROD_W'(wc_q) * lsf_pkg::PROD_W'(sample_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			coef_q   <= '0;
		end else begin
			if (ctl.clear) begin
				sample_q <= '0;
			end else if (ctl.shift) begin
				sample_q <= sample_in;
			end
			if (coef_we) begin
				coef_q <= coef_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wc_load) begin
			wc_q <= keep ? coef_q : '0;
		end else if (ctl.wc_down) begin
			wc_q <= wc_next;
		end else if (ctl.wc_up) begin
			wc_q <= wc_prev;
		end
		prod_q <= mul;
		psum_q <= psum_in + SUM_W'(prod_q);
	end

	assign sample_out = sample_q;
	assign wc_out     = wc_q;
	assign psum_out   = psum_q;

endmodule

// File: hw/rtl/line_smoothing_fir_bad_skip.sv
// Line smoothing filter with a centered kernel, zero padding at the line
// edges and optional skipping of a marker value for missing samples.
// Input items arrive on the s_axis channel. tuser selects the kind: a line
// sample (tdata carries the sample, tlast marks the last sample of a line)
// or a coefficient write (tdata carries the tap index and the coefficient).
// Results leave on the m_axis channel, one smoothed sample per transfer,
// with tlast on the final result of the line.
// A coefficient write leaves the sequencer idle, so the block stays ready
// for the next item. A sample shifts into the delay row; for each result it
// releases, the sequencer loads the working coefficient row, slides it one
// step at a time to the offset the result needs (zero steps in the steady
// state) and lets the partial sum walk the row of cells one cell per cycle.
// The input stays closed until every result of a sample has been worked
// out. The end of a line releases up to half the kernel plus one result.
// The result sits in an output register, so a new sample is taken while the
// last result still waits. A stalled receiver holds the sequencer before it
// would overwrite that register. Reset clears the coefficients, the delay
// row, the line counters and sets the registers to their reset values.
module line_smoothing_fir_bad_skip #(
	parameter int MAX_TAPS = lsf_pkg::MAX_TAPS_DEF,
	parameter int MAX_LINE = lsf_pkg::MAX_LINE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sample [31:0], tap_index [36:32], coefficient [54:37], zero pad [55]
	input  logic [lsf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// kind
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// smoothed [31:0]
	output logic [lsf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int NW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int KW    = NW + 1;
	localparam int TW    = $clog2(MAX_TAPS + 1);
	localparam int CW    = (TW > lsf_pkg::TAPCNT_W) ? TW : lsf_pkg::TAPCNT_W;
	localparam int CMPW  = ((KW > TW) ? KW : TW) + 1;
	localparam int OW    = TW + 1;
	localparam int SUM_W = lsf_pkg::sum_width(MAX_TAPS);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(lsf_pkg::SMOOTH_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(lsf_pkg::SMOOTH_MIN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_ALIGN,
		ST_SUM,
		ST_OUT
	} state_t;

	// Configuration registers.
	logic [lsf_pkg::TAPCNT_W-1:0]        tap_count_q;
	logic                                bad_enable_q;
	logic [lsf_pkg::SAMPLE_W-1:0]        bad_value_q;

	// Sequencer state.
	state_t                              state_q;
	logic [NW-1:0]                       ss_q;      // samples seen in this line
	logic [KW-1:0]                       k_q;       // next result index
	logic                                end_q;     // current sample ends the line
	logic signed [OW-1:0]                cur_o_q;   // offset the working row holds
	logic signed [OW-1:0]                tgt_o_q;   // offset the next result needs
	logic [TW-1:0]                       cnt_q;
	logic [lsf_pkg::M_TDATA_W-1:0]       out_data_q;
	logic                                out_last_q;
	logic                                out_valid_q;

	// Input item decode.
	logic                                in_acc;
	logic                                coef_wr;
	logic                                samp_acc;
	logic signed [lsf_pkg::SAMPLE_W-1:0] s_sample;
	logic [lsf_pkg::TAP_IDX_W-1:0]       tap_idx;
	logic signed [lsf_pkg::COEF_W-1:0]   s_coef;
	logic signed [lsf_pkg::SAMPLE_W-1:0] new_sample;
	logic                                last_pos;

	// Kernel geometry and loop control.
	logic [CW-1:0]                       tc_ext;
	logic [TW-1:0]                       nb;
	logic [TW-1:0]                       h;
	logic [CMPW-1:0]                     n_ext;
	logic [CMPW-1:0]                     k_ext;
	logic [CMPW-1:0]                     h_ext;
	logic                                more;
	logic signed [CMPW:0]                o_full;
	logic                                out_free;
	logic                                out_load;

	// Row of cells.
	lsf_pkg::cell_ctl_t                  ctl;
	logic                                keep    [MAX_TAPS];
	logic                                coef_we [MAX_TAPS];
	logic signed [lsf_pkg::SAMPLE_W-1:0] samp_in [MAX_TAPS];
	logic signed [lsf_pkg::SAMPLE_W-1:0] dl      [MAX_TAPS];
	logic signed [lsf_pkg::COEF_W-1:0]   wcp     [MAX_TAPS];
	logic signed [lsf_pkg::COEF_W-1:0]   wcn     [MAX_TAPS];
	logic signed [lsf_pkg::COEF_W-1:0]   wc      [MAX_TAPS];
	logic signed [SUM_W-1:0]             psum    [MAX_TAPS+1];

	// Output scaling.
	logic signed [SUM_W-1:0]             shifted;
	logic [lsf_pkg::M_TDATA_W-1:0]       sat_val;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign coef_wr       = in_acc && (s_axis_tuser == lsf_pkg::KIND_COEF);
	assign samp_acc      = in_acc && (s_axis_tuser == lsf_pkg::KIND_SAMPLE);

	assign s_sample = s_axis_tdata[lsf_pkg::SAMPLE_LSB +: lsf_pkg::SAMPLE_W];
	assign tap_idx  = s_axis_tdata[lsf_pkg::TAP_LSB +: lsf_pkg::TAP_IDX_W];
	assign s_coef   = s_axis_tdata[lsf_pkg::COEF_LSB +: lsf_pkg::COEF_W];

	// A sample equal to the missing-data marker enters the row as zero.
	assign new_sample = (bad_enable_q && (s_sample == bad_value_q)) ? '0 : s_sample;

	// The longest allowed line ends on its last slot even without tlast.
	assign last_pos = (ss_q == NW'(MAX_LINE - 1));

	// Taps in use: zero counts as one, anything past the row is clipped.
	assign tc_ext = CW'(tap_count_q);
	always_comb begin
		if (tc_ext == '0) begin
			nb = TW'(1);
		end else if (tc_ext > CW'(MAX_TAPS)) begin
			nb = TW'(MAX_TAPS);
		end else begin
			nb = TW'(tc_ext);
		end
	end
	assign h = (nb - TW'(1)) >> 1;

	// Result k is ready once sample k + h is in, or when the line ends.
	assign n_ext = CMPW'(ss_q);
	assign k_ext = CMPW'(k_q);
	assign h_ext = CMPW'(h);
	assign more  = (k_ext <= n_ext) && (((k_ext + h_ext) <= n_ext) || end_q);

	// Cell d must hold coefficient d + h - (n - k) during the sum.
	assign o_full = $signed({1'b0, h_ext}) + $signed({1'b0, k_ext}) - $signed({1'b0, n_ext});

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_OUT) && out_free;

	always_comb begin
		ctl.shift   = samp_acc;
		ctl.clear   = (state_q == ST_CHECK) && !more && end_q;
		ctl.wc_load = (state_q == ST_LOAD);
		ctl.wc_down = (state_q == ST_ALIGN) && (cur_o_q < tgt_o_q);
		ctl.wc_up   = (state_q == ST_ALIGN) && (cur_o_q > tgt_o_q);
	end

	assign psum[0] = '0;

	for (genvar d = 0; d < MAX_TAPS; d++) begin : g_cell
		if (d == 0) begin : g_head
			assign samp_in[d] = new_sample;
			assign wcp[d]     = '0;
		end else begin : g_body
			assign samp_in[d] = dl[d-1];
			assign wcp[d]     = wc[d-1];
		end
		if (d == MAX_TAPS - 1) begin : g_tail
			assign wcn[d] = '0;
		end else begin : g_inner
			assign wcn[d] = wc[d+1];
		end
		assign keep[d]    = (d < int'(nb));
		assign coef_we[d] = coef_wr && (int'(tap_idx) == d);

		lsf_cell #(
			.MAX_TAPS (MAX_TAPS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.keep       (keep[d]),
			.coef_we    (coef_we[d]),
			.coef_in    (s_coef),
			.sample_in  (samp_in[d]),
			.sample_out (dl[d]),
			.wc_prev    (wcp[d]),
			.wc_next    (wcn[d]),
			.wc_out     (wc[d]),
			.psum_in    (psum[d]),
			.psum_out   (psum[d+1])
		);
	end

	// Drop the sixteen fraction bits (rounding toward minus infinity) and
	// clip to the signed output range.
	assign shifted = psum[MAX_TAPS] >>> lsf_pkg::FRAC_BITS;
	always_comb begin
		if (shifted > SAT_HI) begin
			sat_val = lsf_pkg::M_TDATA_W'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			sat_val = lsf_pkg::M_TDATA_W'(SAT_LO);
		end else begin
			sat_val = shifted[lsf_pkg::M_TDATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= lsf_pkg::TAP_COUNT_RST;
			bad_enable_q <= 1'b0;
			bad_value_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsf_pkg::REG_TAP_COUNT: begin
					tap_count_q <= cfg_data[lsf_pkg::TAPCNT_W-1:0];
				end
				lsf_pkg::REG_BAD_ENABLE: begin
					bad_enable_q <= cfg_data[0];
				end
				lsf_pkg::REG_BAD_VALUE: begin
					bad_value_q <= cfg_data[lsf_pkg::SAMPLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: one sample at a time, one result at a time through the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ss_q        <= '0;
			k_q         <= '0;
			end_q       <= 1'b0;
			cur_o_q     <= '0;
			tgt_o_q     <= '0;
			cnt_q       <= '0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A result taken by the receiver frees the register unless a new
			// one is loaded in the same cycle.
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samp_acc) begin
						end_q   <= s_axis_tlast || last_pos;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (more) begin
						tgt_o_q <= o_full[OW-1:0];
						state_q <= ST_LOAD;
					end else begin
						if (end_q) begin
							ss_q <= '0;
							k_q  <= '0;
						end else begin
							ss_q <= ss_q + NW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					cur_o_q <= '0;
					state_q <= ST_ALIGN;
				end
				ST_ALIGN: begin
					if (cur_o_q < tgt_o_q) begin
						cur_o_q <= cur_o_q + OW'(1);
					end else if (cur_o_q > tgt_o_q) begin
						cur_o_q <= cur_o_q - OW'(1);
					end else begin
						cnt_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// The partial sum has to walk the whole row of cells after the products.
					if (cnt_q == TW'(MAX_TAPS)) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + TW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_data_q  <= sat_val;
						out_last_q  <= end_q && (k_ext == n_ext);
						out_valid_q <= 1'b1;
						k_q         <= k_q + KW'(1);
						state_q     <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/lsf_checker.sv
// Port-level checks for the line smoothing filter.
module lsf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [lsf_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);

	// A stalled result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A coefficient write never blocks the next transfer.
	a_coef_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == lsf_pkg::KIND_COEF) |=>
			s_axis_tready)
		else $error("not ready after a coefficient write");

	// A sample keeps the input closed while its results are worked out.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == lsf_pkg::KIND_SAMPLE) |=>
			!s_axis_tready)
		else $error("ready right after a sample");

	// A fresh result only appears while a sample is being worked on.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready)
		else $error("result appeared while idle");

endmodule

bind line_smoothing_fir_bad_skip lsf_checker u_lsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_top.sv
module tb_top;
	import lsf_pkg::*;

	localparam int TAPS     = MAX_TAPS_DEF;
	localparam int LINE_MAX = MAX_LINE_DEF;

	// Twice the worst work of one result, slide steps included, together with
	// an item that releases nothing, covers anything still moving once the
	// last expected result has come.
	localparam int SETTLE = 2 * (2 * TAPS + 8);

	// Longest run of cycles with no transfer at all before the run is called
	// hung. The slowest correct gap is one result behind a long receiver
	// stall or a long sender gap; this is many times that.
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [SMOOTH_W-1:0] smoothed;
		logic                last;
	} smooth_res_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// sample [31:0], tap_index [36:32], coefficient [54:37], zero pad [55]
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	// kind
	logic                  s_axis_tuser  = 1'b0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// smoothed [31:0]
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Our own copy of the filter state: kernel, delay row, line position and
	// the configuration registers as last written.
	longint              kernel [TAPS];
	longint              history [TAPS];
	int                  line_pos;
	int                  line_emitted;
	logic [TAPCNT_W-1:0] tap_reg;
	logic                skip_en;
	logic [SAMPLE_W-1:0] skip_val;

	// Smoothed samples that the block still owes us, oldest first.
	smooth_res_t smooth_q [$];

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int errors        = 0;
	int quiet_cycles  = 0;

	line_smoothing_fir_bad_skip dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Filter prediction
	// ------------------------------------------------------------------

	// A tap count of zero behaves as one tap, and anything above the
	// kernel size is clipped to the full kernel.
	function automatic int taps_in_use();
		int t;
		t = int'(tap_reg);
		if (t < 1)
			t = 1;
		if (t > TAPS)
			t = TAPS;
		return t;
	endfunction

	// Output k of the line while sample n is the newest one in the row.
	// Positions that fall off the row or outside the line add nothing.
	function automatic smooth_res_t smooth_at(int k, int n, logic last);
		int          nb;
		int          ctr;
		int          j;
		longint      acc;
		longint      q;
		smooth_res_t r;
		nb  = taps_in_use();
		ctr = (nb - 1) / 2;
		acc = 0;
		for (int d = 0; d < TAPS && d <= n; d++) begin
			j = k - (n - d) + ctr;
			if (j >= 0 && j < nb)
				acc += kernel[j] * history[d];
		end
		// The sum carries 16 fraction bits; the arithmetic shift floors it.
		q = acc >>> FRAC_BITS;
		if (q > SMOOTH_MAX)
			q = SMOOTH_MAX;
		if (q < SMOOTH_MIN)
			q = SMOOTH_MIN;
		r.smoothed = q[SMOOTH_W-1:0];
		r.last     = last;
		return r;
	endfunction

	function automatic void clear_filter_state();
		for (int d = 0; d < TAPS; d++) begin
			kernel[d]  = 0;
			history[d] = 0;
		end
		line_pos     = 0;
		line_emitted = 0;
		tap_reg      = TAP_COUNT_RST;
		skip_en      = 1'b0;
		skip_val     = '0;
	endfunction

	// Called once per accepted transfer. A coefficient write only updates the
	// kernel; a sample moves the row on and queues every output it releases.
	function automatic void predict_transfer(logic kind, logic [S_TDATA_W-1:0] data,
		logic last);
		logic [SAMPLE_W-1:0] raw;
		logic                line_done;
		int                  n;
		int                  ctr;
		if (kind == KIND_COEF) begin
			kernel[int'(data[TAP_LSB +: TAP_IDX_W])] =
				longint'($signed(data[COEF_LSB +: COEF_W]));
		end else begin
			raw = data[SAMPLE_LSB +: SAMPLE_W];
			for (int d = TAPS - 1; d > 0; d--)
				history[d] = history[d - 1];
			// The marker check uses the registers as they are when the sample
			// arrives; a marked sample sits in the row as zero.
			if (skip_en && raw == skip_val)
				history[0] = 0;
			else
				history[0] = longint'($signed(raw));
			n = line_pos;
			// The last slot of the longest line closes it even without tlast.
			line_done = last || (line_pos >= LINE_MAX - 1);
			ctr = (taps_in_use() - 1) / 2;
			while (line_emitted <= n && (line_emitted + ctr <= n || line_done)) begin
				smooth_q.push_back(smooth_at(line_emitted, n,
					line_done && line_emitted == n));
				line_emitted++;
			end
			if (line_done) begin
				line_pos     = 0;
				line_emitted = 0;
			end else begin
				line_pos++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver, result checker and watchdog
	// ------------------------------------------------------------------

	// The receiver draws its ready afresh every cycle; a stall percentage of
	// zero keeps it ready throughout.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Every result transfer is matched against the oldest outstanding
	// expectation. Values are read at the edge itself, before any update
	// scheduled for this edge takes effect.
	always @(posedge clk) begin
		smooth_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (smooth_q.size() == 0) begin
				errors++;
				$error("smoothed: no result expected, got %0d", $signed(m_axis_tdata));
			end else begin
				want = smooth_q.pop_front();
				if (m_axis_tdata !== want.smoothed) begin
					errors++;
					$error("smoothed: expected %0d, got %0d",
						$signed(want.smoothed), $signed(m_axis_tdata));
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					$error("last_output: expected %0b, got %0b", want.last, m_axis_tlast);
				end
			end
		end
	end

	// Any transfer on either channel or a register write counts as progress.
	// A long stretch without any of them means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
			(m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [S_TDATA_W-1:0] pack_item(logic [SAMPLE_W-1:0] smp,
		logic [TAP_IDX_W-1:0] idx, logic [COEF_W-1:0] cf);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[SAMPLE_LSB +: SAMPLE_W] = smp;
		d[TAP_LSB +: TAP_IDX_W]   = idx;
		d[COEF_LSB +: COEF_W]     = cf;
		return d;
	endfunction

	// Offers one item, with random idle cycles ahead of it, and holds it until
	// the block takes it. tvalid gets exactly one assignment per edge: either
	// low for an idle cycle or high for the item.
	task automatic send_item(logic kind, logic [S_TDATA_W-1:0] data, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= data;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_transfer(kind, data, last);
	endtask

	// The fields a kind does not use carry random bits; the block must ignore
	// them.
	task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic last);
		send_item(KIND_SAMPLE, pack_item(smp, TAP_IDX_W'($urandom()), COEF_W'($urandom())),
			last);
	endtask

	task automatic send_coef(logic [TAP_IDX_W-1:0] idx, logic [COEF_W-1:0] cf);
		send_item(KIND_COEF, pack_item($urandom(), idx, cf), 1'($urandom_range(1)));
	endtask

	// The input is withdrawn first so that an item already taken is not
	// offered again while the register is written.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		cfg_we        <= 1'b1;
		cfg_index     <= idx;
		cfg_data      <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TAP_COUNT:  tap_reg  = val[TAPCNT_W-1:0];
			REG_BAD_ENABLE: skip_en  = val[0];
			REG_BAD_VALUE:  skip_val = val[SAMPLE_W-1:0];
			default: ;
		endcase
	endtask

	// Stops offering items and waits until every expected result has come.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (smooth_q.size() != 0)
			@(posedge clk);
	endtask

	// Drains, then gives the block time to finish any work that releases no
	// result, so that register writes land on an idle block.
	task automatic settle();
		drain_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6:    return SAMPLE_W'($urandom_range(2000) - 1000);
			7:          return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default:    return skip_val;
		endcase
	endfunction

	// Full-range coefficients drive the sum into saturation; moderate ones
	// keep it in range so the rounding shows.
	function automatic logic [COEF_W-1:0] rand_coef();
		if ($urandom_range(2) == 0)
			return COEF_W'($urandom());
		return COEF_W'($urandom_range(40000) - 20000);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default three-tap kernel: first all zero, then extreme coefficients and
	// extreme samples, so that both saturation bounds and the floor of a
	// negative sum come up. A one-sample line closes the test.
	task automatic test_kernel_extremes();
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		send_coef(0, 18'h1ffff);
		send_coef(1, 18'h20000);
		send_coef(2, 18'h10000);
		send_coef(31, 18'h3ffff);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hffff_ffff, 1'b1);
		send_sample(32'h1234_5678, 1'b1);
		settle();
	endtask

	// A tap count of zero runs as one tap, a count above the kernel size as
	// the full kernel; the bits above the register width are ignored.
	task automatic test_tap_count_limits();
		cfg_write(REG_TAP_COUNT, $urandom() & ~32'h3f);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b1);
		settle();
		send_coef(15, rand_coef());
		send_coef(16, rand_coef());
		cfg_write(REG_TAP_COUNT, $urandom() | 32'h3f);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b1);
		settle();
		cfg_write(REG_TAP_COUNT, 32'd32);
		send_sample(rand_sample(), 1'b1);
		settle();
	endtask

	// With skipping on, marker samples at the line edges and in the middle
	// drop out of the sums but still get their own outputs. With skipping
	// off, the same value is an ordinary sample.
	task automatic test_marker_skip();
		cfg_write(REG_TAP_COUNT, 32'd3);
		cfg_write(REG_BAD_VALUE, 32'h8000_0000);
		cfg_write(REG_BAD_ENABLE, $urandom() | 32'h1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'd100, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(-32'sd7, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		settle();
		cfg_write(REG_BAD_ENABLE, $urandom() & ~32'h1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'd5, 1'b1);
		settle();
	endtask

	// The tap count changes twice in the middle of one line, shrinking and
	// then growing; every output uses the count in force when it leaves.
	task automatic test_midline_tap_change();
		cfg_write(REG_TAP_COUNT, 32'd5);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b0);
		settle();
		cfg_write(REG_TAP_COUNT, 32'd1);
		send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b0);
		settle();
		cfg_write(REG_TAP_COUNT, 32'd9);
		send_sample(rand_sample(), 1'b1);
		settle();
	endtask

	// Random lines in four flow-control phases. Each phase picks its own
	// registers and loads part of the kernel, then sends lines of random
	// length. A few lines lose their tlast and run into the next one, and
	// coefficient writes now and then land in the middle of a line. A phase
	// may end mid-line, so the next register writes hit an open line.
	task automatic test_random_lines();
		int idle_pct  [4] = '{0, 68, 0, 34};
		int stall_pct [4] = '{0, 0, 68, 34};
		int tap_pick  [4] = '{32, 1, 0, 0};
		int nb;
		int len;
		int sent;
		logic paused;
		paused = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = idle_pct[ph];
			snk_stall_pct = stall_pct[ph];
			if (tap_pick[ph] != 0)
				nb = tap_pick[ph];
			else if ($urandom_range(3) == 0)
				nb = $urandom_range(63);
			else
				nb = $urandom_range(1, 12);
			cfg_write(REG_TAP_COUNT, nb);
			cfg_write(REG_BAD_ENABLE, $urandom_range(1));
			cfg_write(REG_BAD_VALUE, $urandom_range(1) ? $urandom() : rand_sample());
			repeat (6)
				send_coef(TAP_IDX_W'($urandom_range(taps_in_use() - 1)), rand_coef());
			sent = 0;
			while (sent < 20) begin
				len = $urandom_range(1, 12);
				for (int s = 0; s < len; s++) begin
					if ($urandom_range(99) < 8)
						send_coef(TAP_IDX_W'($urandom()), rand_coef());
					send_sample(rand_sample(),
						s == len - 1 && $urandom_range(9) != 0);
					sent++;
				end
				// Once in the run the sender holds off until the block has
				// delivered everything it owes.
				if (ph == 1 && !paused && sent >= 10) begin
					drain_results();
					paused = 1'b1;
				end
			end
			settle();
		end
		src_idle_pct  = 0;
		snk_stall_pct = 0;
	endtask

	initial begin
		clear_filter_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_kernel_extremes();
		test_tap_count_limits();
		test_marker_skip();
		test_midline_tap_change();
		test_random_lines();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_cell.sv
hw/rtl/line_smoothing_fir_bad_skip.sv
hw/rtl/lsf_checker.sv
bench/tb_top.sv
